// File: design/xrng_pkg.sv
package xrng_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned DRAWS_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Generator rotation and shift amounts
  localparam int unsigned ROT_A = 24;
  localparam int unsigned SHIFT_B = 16;
  localparam int unsigned ROT_C = 37;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND = 2'd1;

  localparam logic [WORD_W-1:0] SEED_FIRST_RST = 64'd1;
  localparam logic [WORD_W-1:0] SEED_SECOND_RST = 64'd0;

  localparam logic [DRAWS_W-1:0] DRAWS_MAX = '1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t first;
    word_t second;
  } gen_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic step;
    logic load_result;
    logic load_error;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bound_zero;
    logic draw_ok;
  } dp_status_t;

  function automatic word_t rot_left(input word_t v, input int unsigned k);
    rot_left = (v << k) | (v >> (WORD_W - k));
  endfunction

  // One xoroshiro128+ state advance
  function automatic gen_state_t gen_next(input gen_state_t s);
    word_t b;
    gen_state_t n;
    b = s.second ^ s.first;
    n.first = rot_left(s.first, ROT_A) ^ b ^ (b << SHIFT_B);
    n.second = rot_left(b, ROT_C);
    gen_next = n;
  endfunction

  // Set every bit below the highest set bit
  function automatic word_t smear_right(input word_t v);
    word_t r;
    r = v;
    r = r | (r >> 1);
    r = r | (r >> 2);
    r = r | (r >> 4);
    r = r | (r >> 8);
    r = r | (r >> 16);
    r = r | (r >> 32);
    smear_right = r;
  endfunction

endpackage

// File: design/xoroshiro128plus_bounded_rng_top.sv
// Channel   Handshake            Payload
// in        in_valid/in_stall    in_action, in_bound
// out       out_valid/out_stall  out_value, out_bound_error, out_draws_used
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A raw draw uses a single generator step; a bounded draw uses N steps,
// N being the generator steps used (one step per cycle in the draw loop).
// A zero bound sets out_bound_error and leaves the generator untouched.
// Synchronous reset loads the state with the seed reset values (1 and 0).
// The result register holds under out_stall; a new request is taken in the
// cycle the held result transfers. cfg_ready is always high.
module xoroshiro128plus_bounded_rng_top import xrng_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [WORD_W-1:0]    in_bound,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_value,
  output logic                 out_bound_error,
  output logic [DRAWS_W-1:0]   out_draws_used
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  xrng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  xrng_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_bound        (in_bound),
    .cmd             (cmd),
    .status          (status),
    .out_value       (out_value),
    .out_bound_error (out_bound_error),
    .out_draws_used  (out_draws_used)
  );

endmodule

// File: design/xrng_dp.sv
module xrng_dp import xrng_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_action,
  input  logic [WORD_W-1:0]    in_bound,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [WORD_W-1:0]    out_value,
  output logic                 out_bound_error,
  output logic [DRAWS_W-1:0]   out_draws_used
);

  gen_state_t           gen_r;
  gen_state_t           gen_nxt;
  logic                 action_r;
  word_t                bound_r;
  word_t                mask_r;
  logic [DRAWS_W-1:0]   count_r;
  logic [DRAWS_W-1:0]   count_nxt;
  word_t                value_r;
  logic                 err_r;
  logic [DRAWS_W-1:0]   draws_r;
  word_t                sum;
  word_t                masked;

  // Output of the current draw and its acceptance
  assign sum = gen_r.first + gen_r.second;
  assign masked = sum & mask_r;
  assign status.draw_ok = !action_r || (masked < bound_r);
  assign status.bound_zero = in_action && (in_bound == '0);

  // Saturating draw count
  assign count_nxt = (count_r == DRAWS_MAX) ? count_r : count_r + DRAWS_W'(1);

  // Generator state: seed writes reload, steps advance
  always_comb begin
    gen_nxt = gen_r;
    if (cmd.step) begin
      gen_nxt = gen_next(gen_r);
    end
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEED_FIRST:  gen_nxt.first = cfg_data;
        REG_SEED_SECOND: gen_nxt.second = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r.first <= SEED_FIRST_RST;
      gen_r.second <= SEED_SECOND_RST;
    end else begin
      gen_r <= gen_nxt;
    end
  end

  // Latch the request; raw draws take the full word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r <= in_action;
      bound_r <= in_bound;
      mask_r <= in_action ? smear_right(in_bound - WORD_W'(1)) : '1;
      count_r <= '0;
    end else if (cmd.step) begin
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_error) begin
      value_r <= '0;
      err_r <= 1'b1;
      draws_r <= '0;
    end else if (cmd.load_result) begin
      value_r <= masked;
      err_r <= 1'b0;
      draws_r <= count_nxt;
    end
  end

  assign out_value = value_r;
  assign out_bound_error = err_r;
  assign out_draws_used = draws_r;

endmodule

// File: design/xrng_ctrl.sv
module xrng_ctrl import xrng_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DRAW = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       can_take;
  logic       in_xfer;

  // Take a new request when idle or as the held result transfers
  assign can_take = (state_r == S_IDLE) || ((state_r == S_DONE) && !out_stall);
  assign in_stall = !can_take;
  assign in_xfer = in_valid && can_take;
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r) inside
      S_IDLE, S_DONE: begin
        if (in_xfer) begin
          if (status.bound_zero) begin
            cmd.load_error = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.load_item = 1'b1;
            state_nxt = S_DRAW;
          end
        end else if (state_r == S_DONE && !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      S_DRAW: begin
        cmd.step = 1'b1;
        if (status.draw_ok) begin
          cmd.load_result = 1'b1;
          state_nxt = S_DONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
